// ----- src/gne_pkg.sv -----
package gne_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int GRAD_WIDTH_DEF  = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [1:0] CMD_EVAL = 2'd0;
  localparam logic [1:0] CMD_PERM = 2'd1;
  localparam logic [1:0] CMD_GRAD = 2'd2;

  localparam logic [1:0] MODE_1D        = 2'd0;
  localparam logic [1:0] MODE_2D_SMOOTH = 2'd1;
  localparam logic [1:0] MODE_2D_QUAD   = 2'd2;
  localparam logic [1:0] MODE_3D        = 2'd3;

  localparam logic [1:0] NOISE_MODE_RST = MODE_2D_SMOOTH;

  typedef struct packed {
    logic full;
    logic empty;
  } gne_q_status_t;

endpackage

// ----- src/gne_ram.sv -----
module gne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/gne_front.sv -----
module gne_front #(
  parameter int AW         = 12,
  parameter int FRAC_BITS  = 16,
  parameter int GRAD_WIDTH = 16,
  parameter int IW         = 2 + 7 * AW + 3 * FRAC_BITS + 8 + 3 * GRAD_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic signed [31:0]    coord_x_i,
  input  logic signed [31:0]    coord_y_i,
  input  logic signed [31:0]    coord_z_i,
  input  logic [11:0]           table_index_i,
  input  logic [7:0]            perm_value_i,
  input  logic signed [15:0]    grad_x_value_i,
  input  logic signed [15:0]    grad_y_value_i,
  input  logic signed [15:0]    grad_z_value_i,
  input  gne_pkg::gne_q_status_t q_status_i,
  output logic                  push_o,
  output logic [IW-1:0]         item_o
);
  import gne_pkg::*;

  localparam int IXW = (AW < 12) ? AW : 12;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [AW-1:0]         x0, x1, y0, y1, z0, z1;
    logic [FRAC_BITS-1:0]  tx, ty, tz;
    logic [AW-1:0]         idx;
    logic [7:0]            pv;
    logic [GRAD_WIDTH-1:0] gx, gy, gz;
  } item_t;

  item_t item_d, item_q;
  logic  vld_d, vld_q;
  logic  accept;
  logic signed [31:0] cell_x, cell_y, cell_z;
  logic signed [GRAD_WIDTH-1:0] gx, gy, gz;

  if (GRAD_WIDTH >= 16) begin : g_grad_wide
    assign gx = GRAD_WIDTH'(grad_x_value_i);
    assign gy = GRAD_WIDTH'(grad_y_value_i);
    assign gz = GRAD_WIDTH'(grad_z_value_i);
  end else begin : g_grad_narrow
    assign gx = grad_x_value_i[GRAD_WIDTH-1:0];
    assign gy = grad_y_value_i[GRAD_WIDTH-1:0];
    assign gz = grad_z_value_i[GRAD_WIDTH-1:0];
  end

  assign cell_x = coord_x_i >>> FRAC_BITS;
  assign cell_y = coord_y_i >>> FRAC_BITS;
  assign cell_z = coord_z_i >>> FRAC_BITS;

  always_comb begin
    item_d.cmd = command_i;
    item_d.x0  = cell_x[AW-1:0];
    item_d.x1  = cell_x[AW-1:0] + AW'(1);
    item_d.y0  = cell_y[AW-1:0];
    item_d.y1  = cell_y[AW-1:0] + AW'(1);
    item_d.z0  = cell_z[AW-1:0];
    item_d.z1  = cell_z[AW-1:0] + AW'(1);
    item_d.tx  = coord_x_i[FRAC_BITS-1:0];
    item_d.ty  = coord_y_i[FRAC_BITS-1:0];
    item_d.tz  = coord_z_i[FRAC_BITS-1:0];
    item_d.idx = AW'(table_index_i[IXW-1:0]);
    item_d.pv  = perm_value_i;
    item_d.gx  = gx;
    item_d.gy  = gy;
    item_d.gz  = gz;
  end

  assign push_o     = vld_q && !q_status_i.full;
  assign in_stall_o = vld_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign vld_d      = accept || (vld_q && !push_o);
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ----- src/gne_queue.sv -----
module gne_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [W-1:0]           data_i,
  input  logic                   pop_i,
  output logic [W-1:0]           data_o,
  output gne_pkg::gne_q_status_t status_o
);
  import gne_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CW-1:0] count_d, count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CW'(DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

// ----- src/gne_back.sv -----
module gne_back #(
  parameter int AW         = 12,
  parameter int FRAC_BITS  = 16,
  parameter int GRAD_WIDTH = 16,
  parameter int IW         = 2 + 7 * AW + 3 * FRAC_BITS + 8 + 3 * GRAD_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             mode_i,
  input  gne_pkg::gne_q_status_t q_status_i,
  input  logic [IW-1:0]          item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [18:0]     noise_value_o
);
  import gne_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int G     = GRAD_WIDTH - 1;
  localparam int DEPTH = 1 << AW;
  localparam int NS    = 12;
  localparam int WW    = F + 2;
  localparam int PW    = GRAD_WIDTH + F + 1;
  localparam int VW    = F + 5;
  localparam int BPW   = VW + 1 + WW + 1;
  localparam int CVW   = VW + 17;
  localparam int DN    = (F > 16) ? F - 16 : 0;
  localparam int UP    = (F < 16) ? 16 - F : 0;
  localparam logic [WW-1:0] THREE_Q = WW'(3) << F;
  localparam logic signed [CVW-1:0] SAT_MAX = CVW'(262143);
  localparam logic signed [CVW-1:0] SAT_MIN = -CVW'(262144);

  typedef struct packed {
    logic [1:0]            cmd;
    logic [AW-1:0]         x0, x1, y0, y1, z0, z1;
    logic [F-1:0]          tx, ty, tz;
    logic [AW-1:0]         idx;
    logic [7:0]            pv;
    logic [GRAD_WIDTH-1:0] gx, gy, gz;
  } item_t;

  typedef struct packed {
    item_t         it;
    logic [WW-1:0] wx, wy, wz;
  } stage_t;

  function automatic logic signed [BPW-1:0] blend_mul(input logic signed [VW-1:0] a,
                                                      input logic signed [VW-1:0] b,
                                                      input logic [WW-1:0] w);
    logic signed [VW:0] df;
    logic signed [WW:0] ws;
    df = (VW + 1)'(a) - (VW + 1)'(b);
    ws = $signed({1'b0, w});
    return BPW'(df * ws);
  endfunction

  function automatic logic signed [VW-1:0] blend_fin(input logic signed [BPW-1:0] p,
                                                     input logic signed [VW-1:0] a);
    return VW'(a - (p >>> F));
  endfunction

  logic          adv;
  item_t         head;
  logic          head_vld;
  stage_t        st_d [1:NS];
  stage_t        st_q [1:NS];
  logic [NS:1]   vld_d, vld_q;

  logic [7:0]    p1 [2];
  logic [7:0]    h2 [4];
  logic [7:0]    g3 [8];
  logic [AW-1:0] h_q [4];
  logic [3*GRAD_WIDTH-1:0] gd [8];

  logic [F-1:0]    head_t [3];
  logic [F-1:0]    st1_t [3];
  logic [2*F-1:0]  sq_q [3];
  logic [F-1:0]    t2_q [3];
  logic [2*F+1:0]  sm_q [3];
  logic [WW-1:0]   sm [3];
  logic [WW-1:0]   t2w [3];

  logic signed [PW-1:0]  pr_q [8][3];
  logic signed [VW-1:0]  dot_q [8];
  logic signed [BPW-1:0] xp_q [4];
  logic signed [VW-1:0]  xa_q [4];
  logic signed [VW-1:0]  lx_q [4];
  logic signed [BPW-1:0] yp_q [2];
  logic signed [VW-1:0]  ya_q [2];
  logic signed [VW-1:0]  ly_q [2];
  logic signed [BPW-1:0] zp_q;
  logic signed [VW-1:0]  za_q;
  logic signed [VW-1:0]  lz_q;

  logic signed [CVW-1:0] cv;
  logic signed [18:0]    sat;
  logic                  out_vld_q;
  logic signed [18:0]    out_val_q;

  assign adv      = !(out_vld_q && out_stall_i);
  assign head     = item_t'(item_i);
  assign head_vld = !q_status_i.empty;
  assign pop_o    = adv && head_vld;

  assign head_t[0] = head.tx;
  assign head_t[1] = head.ty;
  assign head_t[2] = head.tz;
  assign st1_t[0]  = st_q[1].it.tx;
  assign st1_t[1]  = st_q[1].it.ty;
  assign st1_t[2]  = st_q[1].it.tz;

  for (genvar c = 0; c < 3; c++) begin : g_wt
    assign sm[c]  = sm_q[c][2*F+1:F];
    assign t2w[c] = WW'(t2_q[c]);
  end

  // stage advance; weights settle on entry to stage 3
  always_comb begin
    st_d[1].it = head;
    st_d[1].wx = '0;
    st_d[1].wy = '0;
    st_d[1].wz = '0;
    vld_d[1]   = head_vld;
    for (int k = 2; k <= NS; k++) begin
      st_d[k]  = st_q[k-1];
      vld_d[k] = vld_q[k-1];
    end
    st_d[3].wx = (mode_i == MODE_2D_QUAD) ? t2w[0] : sm[0];
    st_d[3].wy = (mode_i == MODE_1D) ? '0 : ((mode_i == MODE_2D_QUAD) ? t2w[1] : sm[1]);
    st_d[3].wz = (mode_i == MODE_3D) ? sm[2] : '0;
  end

  // first hash level: perm of the x cells
  for (genvar j = 0; j < 2; j++) begin : g_l1
    gne_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (adv && head_vld && head.cmd == CMD_PERM),
      .waddr_i (head.idx),
      .wdata_i (head.pv),
      .re_i    (adv),
      .raddr_i ((j == 1) ? head.x1 : head.x0),
      .rdata_o (p1[j])
    );
  end

  // second level: slot bit 0 picks x, bit 1 picks y
  for (genvar j = 0; j < 4; j++) begin : g_l2
    gne_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (adv && vld_q[1] && st_q[1].it.cmd == CMD_PERM),
      .waddr_i (st_q[1].it.idx),
      .wdata_i (st_q[1].it.pv),
      .re_i    (adv),
      .raddr_i (((j >= 2) ? st_q[1].it.y1 : st_q[1].it.y0) + AW'(p1[j % 2])),
      .rdata_o (h2[j])
    );
  end

  // third level: slot bit 2 picks z
  for (genvar k = 0; k < 8; k++) begin : g_l3
    gne_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (adv && vld_q[2] && st_q[2].it.cmd == CMD_PERM),
      .waddr_i (st_q[2].it.idx),
      .wdata_i (st_q[2].it.pv),
      .re_i    (adv),
      .raddr_i (((k >= 4) ? st_q[2].it.z1 : st_q[2].it.z0) + AW'(h2[k % 4])),
      .rdata_o (g3[k])
    );
  end

  for (genvar k = 0; k < 8; k++) begin : g_grad
    logic [AW-1:0] gaddr;
    always_comb begin
      unique case (mode_i)
        MODE_1D: gaddr = (k % 2 == 1) ? st_q[3].it.x1 : st_q[3].it.x0;
        MODE_3D: gaddr = AW'(g3[k]);
        default: gaddr = h_q[k % 4];
      endcase
    end
    gne_ram #(.WIDTH(3 * GRAD_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (adv && vld_q[3] && st_q[3].it.cmd == CMD_GRAD),
      .waddr_i (st_q[3].it.idx),
      .wdata_i ({st_q[3].it.gx, st_q[3].it.gy, st_q[3].it.gz}),
      .re_i    (adv),
      .raddr_i (gaddr),
      .rdata_o (gd[k])
    );
  end

  assign cv  = (CVW'(lz_q) >>> DN) <<< UP;
  assign sat = (cv > SAT_MAX) ? 19'(SAT_MAX) : ((cv < SAT_MIN) ? 19'(SAT_MIN) : 19'(cv));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[NS] && st_q[NS].it.cmd == CMD_EVAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 1; k <= NS; k++) begin
        st_q[k] <= st_d[k];
      end
      for (int c = 0; c < 3; c++) begin
        sq_q[c] <= head_t[c] * head_t[c];
        t2_q[c] <= sq_q[c][2*F-1:F];
        sm_q[c] <= (THREE_Q - {1'b0, st1_t[c], 1'b0}) * sq_q[c][2*F-1:F];
      end
      for (int j = 0; j < 4; j++) begin
        h_q[j] <= AW'(h2[j]);
      end
      for (int k = 0; k < 8; k++) begin
        pr_q[k][0] <= $signed(gd[k][3*GRAD_WIDTH-1:2*GRAD_WIDTH])
                      * $signed({k[0], st_q[4].it.tx});
        pr_q[k][1] <= (st_q[4].wy == '0 && mode_i == MODE_1D) ? $signed(PW'(0))
                      : $signed(gd[k][2*GRAD_WIDTH-1:GRAD_WIDTH])
                        * $signed({k[1], st_q[4].it.ty});
        pr_q[k][2] <= (mode_i != MODE_3D) ? $signed(PW'(0))
                      : $signed(gd[k][GRAD_WIDTH-1:0]) * $signed({k[2], st_q[4].it.tz});
        dot_q[k]   <= VW'(((PW + 2)'(pr_q[k][0]) + (PW + 2)'(pr_q[k][1])
                          + (PW + 2)'(pr_q[k][2])) >>> G);
      end
      for (int i = 0; i < 4; i++) begin
        xp_q[i] <= blend_mul(dot_q[2*i], dot_q[2*i+1], st_q[6].wx);
        xa_q[i] <= dot_q[2*i];
        lx_q[i] <= blend_fin(xp_q[i], xa_q[i]);
      end
      for (int i = 0; i < 2; i++) begin
        yp_q[i] <= blend_mul(lx_q[2*i], lx_q[2*i+1], st_q[8].wy);
        ya_q[i] <= lx_q[2*i];
        ly_q[i] <= blend_fin(yp_q[i], ya_q[i]);
      end
      zp_q      <= blend_mul(ly_q[0], ly_q[1], st_q[10].wz);
      za_q      <= ly_q[0];
      lz_q      <= blend_fin(zp_q, za_q);
      out_val_q <= sat;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign noise_value_o = out_val_q;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved while output held");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !q_status_i.empty)
    else $error("pop from empty queue");
  a_eval_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[NS] && st_q[NS].it.cmd == CMD_EVAL) |=> out_valid_o)
    else $error("evaluate request lost at output");
  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (!vld_q[NS] || st_q[NS].it.cmd != CMD_EVAL)) |=> !out_valid_o)
    else $error("result without evaluate request");
`endif

endmodule

// ----- src/gradient_noise_evaluator.sv -----
// Gradient noise evaluator: while not stalled it takes one request per clock (an evaluate
// or a table load) and, for each evaluate, returns one saturated Q3.16 noise value.
// The rate of one request per cycle is set by the back-end pipeline of twelve stages,
// where each hash level and the gradient fetch read their own copy of the tables;
// every copy takes a load as the load passes the stage that reads it, so requests see
// the tables in request order. A stall on the result side freezes the back end, and a
// two-entry queue behind the input register keeps the front accepting meanwhile. The
// tables are not cleared after reset and must be loaded before they are used. The mode
// register may only be written while no request is in flight.
module gradient_noise_evaluator #(
  parameter int TABLE_DEPTH = gne_pkg::TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = gne_pkg::FRAC_BITS_DEF,
  parameter int GRAD_WIDTH  = gne_pkg::GRAD_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [11:0]        table_index_i,
  input  logic [7:0]         perm_value_i,
  input  logic signed [15:0] grad_x_value_i,
  input  logic signed [15:0] grad_y_value_i,
  input  logic signed [15:0] grad_z_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [18:0] noise_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i
);
  import gne_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = 2 + 7 * AW + 3 * FRAC_BITS + 8 + 3 * GRAD_WIDTH;

  logic [1:0]    mode_q;
  logic          push;
  logic          pop;
  logic [IW-1:0] front_item;
  logic [IW-1:0] head_item;
  gne_q_status_t q_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= NOISE_MODE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  gne_front #(
    .AW(AW), .FRAC_BITS(FRAC_BITS), .GRAD_WIDTH(GRAD_WIDTH), .IW(IW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .table_index_i  (table_index_i),
    .perm_value_i   (perm_value_i),
    .grad_x_value_i (grad_x_value_i),
    .grad_y_value_i (grad_y_value_i),
    .grad_z_value_i (grad_z_value_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .item_o         (front_item)
  );

  gne_queue #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (front_item),
    .pop_i    (pop),
    .data_o   (head_item),
    .status_o (q_status)
  );

  gne_back #(
    .AW(AW), .FRAC_BITS(FRAC_BITS), .GRAD_WIDTH(GRAD_WIDTH), .IW(IW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .q_status_i    (q_status),
    .item_i        (head_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .noise_value_o (noise_value_o)
  );

endmodule
